// ===== src/online_kmeans_assign_update_assert.svh =====
// Assertion macros shared by the online k-means RTL.
// Needs no other file; defining SYNTH turns every macro into nothing.
`ifndef ONLINE_KMEANS_ASSIGN_UPDATE_ASSERT_SVH
`define ONLINE_KMEANS_ASSIGN_UPDATE_ASSERT_SVH

`ifndef SYNTH
`define OKM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define OKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OKM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define OKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/okm_pkg.sv =====
// Package for the online k-means block: widths, codes, beat and control types.
// Used by the lane, merge and top files of the block; depends on nothing.
package okm_pkg;

  localparam int DIMS        = 4;
  localparam int COORD_W     = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = 34;
  localparam int CIDX_W      = 5;
  localparam int CENTERS_W   = 6;
  localparam int DIMS_CFG_W  = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_IDX_W-1:0]  CFG_CENTERS = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_DIMS    = 1'd1;
  localparam logic [CENTERS_W-1:0]  CENTERS_RST = 6'd30;
  localparam logic [DIMS_CFG_W-1:0] DIMS_RST    = 3'd4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_POINT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              func;
    logic [CIDX_W-1:0] center_index;
    coord_t            coord_0;
    coord_t            coord_1;
    coord_t            coord_2;
    coord_t            coord_3;
  } in_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0] cluster_index;
    logic [DIST_W-1:0] min_distance_sq;
  } out_item_t;

  typedef struct packed {
    logic load_we;
    logic pt_latch;
    logic rd_en;
    logic mean_we;
  } lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic issue;
  } merge_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RDWIN,
    ST_WRBACK,
    ST_DONE
  } okm_state_t;

endpackage

// ===== src/okm_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
// The payload type comes in as a parameter, normally from okm_pkg.
interface okm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/okm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module okm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/okm_lane.sv =====
// One coordinate lane: its slice of the center store, the squared difference
// and the running-mean write-back. Depends on okm_pkg and okm_ram.
module okm_lane #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  okm_pkg::lane_ctrl_t     ctrl,
  input  logic                    lane_on,
  input  logic [AW-1:0]           rd_addr,
  input  logic [AW-1:0]           wr_addr,
  input  okm_pkg::coord_t         coord_in,
  output logic [okm_pkg::SQ_W-1:0] sq_out
);
  import okm_pkg::*;

  coord_t                    pt_r;
  coord_t                    rd_data;
  coord_t                    wdata;
  coord_t                    mean;
  logic                      we;
  logic signed [COORD_W:0]   diff;
  logic signed [COORD_W:0]   sum;
  logic signed [2*COORD_W+1:0] prod;
  logic [SQ_W-1:0]           sq_r;

  always_ff @(posedge clk) begin
    if (ctrl.pt_latch) begin
      pt_r <= coord_in;
    end
  end

  okm_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    diff = {rd_data[COORD_W-1], rd_data} - {pt_r[COORD_W-1], pt_r};
    prod = diff * diff;
    // Dropping the low bit of the sign-extended sum gives the floored mean.
    sum  = {rd_data[COORD_W-1], rd_data} + {pt_r[COORD_W-1], pt_r};
    mean = sum[COORD_W:1];
    we    = ctrl.load_we | (ctrl.mean_we & lane_on);
    wdata = ctrl.load_we ? coord_in : mean;
  end

  // The square of a 17-bit difference is below 2**32, so the low half is exact.
  always_ff @(posedge clk) begin
    sq_r <= lane_on ? prod[SQ_W-1:0] : '0;
  end

  assign sq_out = sq_r;

endmodule

// ===== src/okm_merge.sv =====
// Merging stage: adds the lane squares and keeps the nearest center so far.
// Depends on okm_pkg.
module okm_merge #(
  parameter int IDX_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  okm_pkg::merge_ctrl_t       ctrl,
  input  logic [IDX_W-1:0]           issue_idx,
  input  logic [okm_pkg::SQ_W-1:0]   sq_in [okm_pkg::DIMS],
  output logic [IDX_W-1:0]           best_idx,
  output logic [okm_pkg::DIST_W-1:0] best_dist,
  output logic                       busy
);
  import okm_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r;
  logic [DIST_W-1:0] sum_nxt, sum_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic              have_r;

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < DIMS; d++) begin
      sum_nxt = sum_nxt + DIST_W'(sq_in[d]);
    end
  end

  // Stage one is the RAM read, stage two the lane squares, stage three the sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      have_r <= 1'b0;
    end else begin
      v1_r <= ctrl.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (ctrl.clear) begin
        have_r <= 1'b0;
      end else if (v3_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= issue_idx;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    sum_r  <= sum_nxt;
    // Strictly smaller only, so a tie keeps the lower index.
    if (v3_r && (!have_r || sum_r < best_dist_r)) begin
      best_dist_r <= sum_r;
      best_idx_r  <= idx3_r;
    end
  end

  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

// ===== src/online_kmeans_assign_update.sv =====
// Channel  Dir  Beat contents                              Handshake
// in_ch    in   func, center_index, coord_0..coord_3       valid/ready
// out_ch   out  cluster_index, min_distance_sq             valid/ready
// cfg_*    in   cfg_index, cfg_data                        cfg_we, no wait
//
// A load beat writes all four lanes at once, if its center_index is below MAX_CENTERS.
// A point beat is accepted, then N center reads run across the lanes, N being the
// saturated centers_in_use, the square and merge stages drain, and then come the
// winner read, its mean write-back and the result load, in that order.
// Reset is synchronous and active low; the center store has no reset.
// A waiting result stalls only the next point at its final step.
`include "online_kmeans_assign_update_assert.svh"

module online_kmeans_assign_update #(
  parameter int MAX_CENTERS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [okm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [okm_pkg::CFG_DATA_W-1:0] cfg_data,
  okm_stream_if.sink                     in_ch,
  okm_stream_if.source                   out_ch
);
  import okm_pkg::*;

  localparam int IDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;

  okm_state_t             state_r, state_nxt;
  logic [CENTERS_W-1:0]   cfg_centers_r;
  logic [DIMS_CFG_W-1:0]  cfg_dims_r;
  logic [IDX_W-1:0]       scan_cnt_r, last_r, last_nxt;
  logic [DIMS-1:0]        lane_on_r, lane_on_nxt;
  logic [DIMS_CFG_W-1:0]  dims_sat;
  logic                   out_valid_r;
  out_item_t              out_item_r;
  logic                   out_load;
  logic                   in_acc;
  logic                   slot_ok;
  lane_ctrl_t             lctl;
  merge_ctrl_t            mctl;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  coord_t                 coords [DIMS];
  logic [SQ_W-1:0]        sq [DIMS];
  logic [IDX_W-1:0]       best_idx;
  logic [DIST_W-1:0]      best_dist;
  logic                   merge_busy;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign slot_ok = 32'(in_ch.data.center_index) < MAX_CENTERS;

  assign coords[0] = in_ch.data.coord_0;
  assign coords[1] = in_ch.data.coord_1;
  assign coords[2] = in_ch.data.coord_2;
  assign coords[3] = in_ch.data.coord_3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_centers_r <= CENTERS_RST;
      cfg_dims_r    <= DIMS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTERS: cfg_centers_r <= cfg_data;
        CFG_DIMS:    cfg_dims_r    <= cfg_data[DIMS_CFG_W-1:0];
        default:     ;
      endcase
    end
  end

  // Register values outside their range are clamped when a point starts.
  always_comb begin
    if (cfg_centers_r == '0) begin
      last_nxt = '0;
    end else if (32'(cfg_centers_r) > MAX_CENTERS) begin
      last_nxt = IDX_W'(MAX_CENTERS - 1);
    end else begin
      last_nxt = IDX_W'(cfg_centers_r - CENTERS_W'(1));
    end
    if (cfg_dims_r == '0) begin
      dims_sat = DIMS_CFG_W'(1);
    end else if (32'(cfg_dims_r) > DIMS) begin
      dims_sat = DIMS_CFG_W'(DIMS);
    end else begin
      dims_sat = cfg_dims_r;
    end
    for (int d = 0; d < DIMS; d++) begin
      lane_on_nxt[d] = 32'(dims_sat) > d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    lctl        = '0;
    mctl        = '0;
    rd_addr     = scan_cnt_r;
    wr_addr     = best_idx;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (in_ch.data.func == FUNC_LOAD) begin
            lctl.load_we = slot_ok;
            wr_addr      = IDX_W'(in_ch.data.center_index);
          end else begin
            lctl.pt_latch = 1'b1;
            mctl.clear    = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        lctl.rd_en = 1'b1;
        mctl.issue = 1'b1;
        if (scan_cnt_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!merge_busy) begin
          state_nxt = ST_RDWIN;
        end
      end
      ST_RDWIN: begin
        lctl.rd_en = 1'b1;
        rd_addr    = best_idx;
        state_nxt  = ST_WRBACK;
      end
      ST_WRBACK: begin
        lctl.mean_we = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lctl.pt_latch) begin
      scan_cnt_r <= '0;
      last_r     <= last_nxt;
      lane_on_r  <= lane_on_nxt;
    end else if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + IDX_W'(1);
    end
  end

  for (genvar d = 0; d < DIMS; d++) begin : g_lane
    okm_lane #(.DEPTH(MAX_CENTERS)) u_lane (
      .clk      (clk),
      .ctrl     (lctl),
      .lane_on  (lane_on_r[d] | lctl.load_we),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .coord_in (coords[d]),
      .sq_out   (sq[d])
    );
  end

  okm_merge #(.IDX_W(IDX_W)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (mctl),
    .issue_idx (scan_cnt_r),
    .sq_in     (sq),
    .best_idx  (best_idx),
    .best_dist (best_dist),
    .busy      (merge_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.cluster_index   <= CIDX_W'(best_idx);
      out_item_r.min_distance_sq <= best_dist;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  `OKM_ASSERT_IMPL(a_win_read_after_drain, clk, rst_n, state_r == ST_RDWIN, !merge_busy, "winner read while merge stages still busy")
  `OKM_ASSERT_IMPL(a_wb_after_read, clk, rst_n, state_r == ST_WRBACK, $past(state_r) == ST_RDWIN, "write-back without a fresh winner read")
  `OKM_ASSERT_IMPL(a_result_from_point, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_DONE, "result beat raised outside the final step of a point")
  `OKM_ASSERT_IMPL(a_scan_in_range, clk, rst_n, state_r == ST_SCAN, scan_cnt_r <= last_r, "scan counter ran past the last center")

endmodule
